[hw/rtl/mfs_pkg.sv]
// Shared types, character constants and CRC/hex helpers for the Modbus frame sender.
package mfs_pkg;

    localparam int unsigned MAX_SLOTS = 7;
    localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam logic FRAMING_BIN = 1'b0;
    localparam logic FRAMING_HEX = 1'b1;

    // One input byte expands into this list of line bytes.
    typedef struct packed {
        logic [MAX_SLOTS-1:0][7:0] slots;
        logic [CNT_W-1:0]          count;
        logic                      eof;
    } job_t;

    // Bitwise CRC-16 update over one byte, reflected polynomial.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = CHAR_ZERO + {4'h0, nib};
        else
            r = CHAR_UPPER_A + {4'h0, nib} - 8'd10;
        return r;
    endfunction

endpackage

[hw/rtl/modbus_frame_sender.sv]
// Top level of the Modbus frame sender: input register, check state and output byte queue.
//
// The sender takes a Modbus reply one payload byte per input transaction and
// produces the bytes or characters for the serial line, one per output
// transaction. With framing_mode 0 (RTU) each byte passes through while a
// CRC-16 runs over it, and the CRC low and high bytes follow the last byte
// unless check_present says the frame already carries them. With framing_mode
// 1 (ASCII) the frame opens with ':', each byte becomes two upper-case hex
// characters, and the LRC (as hex, unless check_present) and CR LF close it.
// Each input byte expands into its line bytes: one for RTU inner bytes, two for
// ASCII inner bytes, up to seven for an ASCII frame end. The output queue hands
// out one byte per cycle while out_ready is high; a next input byte already held
// in the input register is expanded into the queue in the same cycle the previous
// item's final byte leaves.
// framing_mode is written through its own channel, which is always ready;
// write it only while the sender is idle.
module modbus_frame_sender (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       framing_mode,
    // Input byte channel.
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       check_present,
    // Line byte channel.
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       last_of_item,
    output logic       end_of_frame
);
    import mfs_pkg::*;

    // Configuration register.
    logic mode_reg, mode_next;

    // Input register holding one accepted transaction.
    logic       in_full_reg, in_full_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       in_check_reg;

    // Running check state across a frame.
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  lrc_reg, lrc_next;
    logic        start_reg, start_next;

    // Output queue: slot 0 is on the line, the rest shift down as bytes leave.
    logic [MAX_SLOTS-1:0][7:0] slots_reg, slots_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      eof_reg, eof_next;

    job_t        job;
    logic [15:0] crc_upd;
    logic [7:0]  lrc_upd;
    logic        in_fire;
    logic        out_fire;
    logic        load;

    mfs_job_builder u_builder (
        .data_byte     (in_data_reg),
        .last_byte     (in_last_reg),
        .check_present (in_check_reg),
        .mode          (mode_reg),
        .at_start      (start_reg),
        .crc           (crc_reg),
        .lrc           (lrc_reg),
        .job           (job),
        .crc_next      (crc_upd),
        .lrc_next      (lrc_upd)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;

    // The held item moves into the queue when the queue is empty or its final
    // byte is leaving in this cycle.
    assign load     = in_full_reg &&
                      ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready));
    assign in_ready = !in_full_reg || load;
    assign in_fire  = in_valid && in_ready;

    assign line_byte    = slots_reg[0];
    assign last_of_item = (cnt_reg == CNT_W'(1));
    assign end_of_frame = (cnt_reg == CNT_W'(1)) && eof_reg;

    always_comb
    begin
        mode_next    = (cfg_valid && cfg_ready) ? framing_mode : mode_reg;
        in_full_next = in_fire ? 1'b1 : (load ? 1'b0 : in_full_reg);
        crc_next     = load ? crc_upd : crc_reg;
        lrc_next     = load ? lrc_upd : lrc_reg;
        start_next   = load ? in_last_reg : start_reg;

        slots_next = slots_reg;
        cnt_next   = cnt_reg;
        eof_next   = eof_reg;
        if (load)
        begin
            slots_next = job.slots;
            cnt_next   = job.count;
            eof_next   = job.eof;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_SLOTS - 1; i++)
                slots_next[i] = slots_reg[i + 1];
            slots_next[MAX_SLOTS-1] = '0;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= FRAMING_BIN;
            in_full_reg <= 1'b0;
            crc_reg     <= CRC_INIT;
            lrc_reg     <= 8'h00;
            start_reg   <= 1'b1;
            cnt_reg     <= '0;
            eof_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            in_full_reg <= in_full_next;
            crc_reg     <= crc_next;
            lrc_reg     <= lrc_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            eof_reg     <= eof_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg  <= data_byte;
            in_last_reg  <= last_byte;
            in_check_reg <= check_present;
        end
        slots_reg <= slots_next;
    end

endmodule

[hw/rtl/mfs_job_builder.sv]
// Expands one registered input byte into its list of line bytes and next check state.
module mfs_job_builder (
    input  logic         [7:0]  data_byte,
    input  logic                last_byte,
    input  logic                check_present,
    input  logic                mode,
    input  logic                at_start,
    input  logic         [15:0] crc,
    input  logic         [7:0]  lrc,
    output mfs_pkg::job_t       job,
    output logic         [15:0] crc_next,
    output logic         [7:0]  lrc_next
);
    import mfs_pkg::*;

    logic [15:0]      crc_upd;
    logic [7:0]       lrc_upd;
    logic [7:0]       lrc_chk;
    logic [CNT_W-1:0] n;

    assign crc_upd  = crc_feed(crc, data_byte);
    assign lrc_upd  = lrc + data_byte;
    assign lrc_chk  = 8'h00 - lrc_upd;
    assign crc_next = last_byte ? CRC_INIT : crc_upd;
    assign lrc_next = last_byte ? 8'h00 : lrc_upd;

    always_comb
    begin
        job = '0;
        n   = '0;
        if (mode == FRAMING_HEX)
        begin
            if (at_start)
            begin
                job.slots[n] = CHAR_COLON;
                n = n + 1'b1;
            end
            job.slots[n] = hex_char(data_byte[7:4]);
            n = n + 1'b1;
            job.slots[n] = hex_char(data_byte[3:0]);
            n = n + 1'b1;
        end
        else
        begin
            job.slots[n] = data_byte;
            n = n + 1'b1;
        end

        if (last_byte)
        begin
            if (mode == FRAMING_HEX)
            begin
                if (!check_present)
                begin
                    job.slots[n] = hex_char(lrc_chk[7:4]);
                    n = n + 1'b1;
                    job.slots[n] = hex_char(lrc_chk[3:0]);
                    n = n + 1'b1;
                end
                job.slots[n] = CHAR_CR;
                n = n + 1'b1;
                job.slots[n] = CHAR_LF;
                n = n + 1'b1;
            end
            else if (!check_present)
            begin
                job.slots[n] = crc_upd[7:0];
                n = n + 1'b1;
                job.slots[n] = crc_upd[15:8];
                n = n + 1'b1;
            end
        end
        job.count = n;
        job.eof   = last_byte;
    end

endmodule

[verif/modbus_frame_sender_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus frame sender: RTU and ASCII framing with random traffic.
module modbus_frame_sender_tb;
    import mfs_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Settle time after the last line byte before a mode write or the verdict.
    localparam int LINE_PAUSE = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       chk;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       item_end;
        logic       frame_end;
    } line_rec_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       framing_mode = FRAMING_BIN;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       check_present = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] line_byte;
    logic       last_of_item;
    logic       end_of_frame;

    // Payload bytes waiting to be offered, and line bytes the sender still owes us.
    byte_item_t pending_bytes[$];
    line_rec_t  line_expect_q[$];
    byte_item_t next_byte;
    line_rec_t  want;

    // Shadow copy of the framer state.
    logic        mode_now = FRAMING_BIN;
    logic [15:0] crc_run = 16'hFFFF;
    logic [7:0]  lrc_run = 8'h00;
    logic        frame_open = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_total = 0;
    int frames_done = 0;
    int rtu_bytes = 0;
    int ascii_bytes = 0;
    int lines_checked = 0;
    int mode_writes = 0;
    int quiet_cycles = 0;

    modbus_frame_sender dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .framing_mode (framing_mode),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .check_present(check_present),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_byte    (line_byte),
        .last_of_item (last_of_item),
        .end_of_frame (end_of_frame)
    );

    always #2 clk = ~clk;

    // CRC-16 over one byte, LSB first, reflected polynomial 0xA001.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = {1'b0, c[15:1]} ^ 16'hA001;
            else
                c = {1'b0, c[15:1]};
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + 8'(nib);
        return CHAR_UPPER_A + 8'(nib) - 8'd10;
    endfunction

    function automatic line_rec_t plain_line(input logic [7:0] c);
        line_rec_t r;
        r.ch = c;
        r.item_end = 1'b0;
        r.frame_end = 1'b0;
        return r;
    endfunction

    // Works out the line bytes that one accepted payload byte must produce, and
    // advances the shadow CRC, LRC and start-of-frame state the same way the
    // framer does. The mode is sampled per byte, so a frame may change mode midway:
    // the colon only appears when a frame opens in ASCII, and the trailer follows
    // the mode in force on the last byte.
    task automatic expand_byte(input logic [7:0] b, input logic lst, input logic chk);
        line_rec_t  recs [8];
        logic [7:0] lrc_out;
        int         n;
        n = 0;
        if (mode_now == FRAMING_HEX)
        begin
            ascii_bytes++;
            if (!frame_open)
            begin
                recs[n] = plain_line(CHAR_COLON);
                n++;
            end
            recs[n] = plain_line(hex_digit(b[7:4]));
            recs[n+1] = plain_line(hex_digit(b[3:0]));
            n += 2;
        end
        else
        begin
            rtu_bytes++;
            recs[n] = plain_line(b);
            n++;
        end
        frame_open = 1'b1;
        crc_run = crc16_step(crc_run, b);
        lrc_run = lrc_run + b;

        // The check flag only matters on the closing byte of a frame.
        if (lst)
        begin
            if (mode_now == FRAMING_HEX)
            begin
                if (!chk)
                begin
                    lrc_out = 8'h00 - lrc_run;
                    recs[n] = plain_line(hex_digit(lrc_out[7:4]));
                    recs[n+1] = plain_line(hex_digit(lrc_out[3:0]));
                    n += 2;
                end
                recs[n] = plain_line(CHAR_CR);
                recs[n+1] = plain_line(CHAR_LF);
                n += 2;
            end
            else if (!chk)
            begin
                recs[n] = plain_line(crc_run[7:0]);
                recs[n+1] = plain_line(crc_run[15:8]);
                n += 2;
            end
            recs[n-1].frame_end = 1'b1;
            crc_run = 16'hFFFF;
            lrc_run = 8'h00;
            frame_open = 1'b0;
            frames_done++;
        end
        recs[n-1].item_end = 1'b1;
        for (int i = 0; i < n; i++)
            line_expect_q.push_back(recs[i]);
    endtask

    // Input driver: offers the next pending byte, holding it steady until the
    // sender takes it. The expected line bytes are worked out at the moment of
    // the transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
            check_present <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expand_byte(data_byte, last_byte, check_present);
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_byte.data;
                    last_byte <= next_byte.last;
                    check_present <= next_byte.chk;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: applies random back-pressure and checks every line byte
    // against the oldest one still owed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                lines_checked++;
                if (line_expect_q.size() == 0)
                begin
                    $display("%0t: line byte %h with nothing expected", $time, line_byte);
                    mismatch_total++;
                end
                else
                begin
                    want = line_expect_q.pop_front();
                    if (line_byte !== want.ch)
                    begin
                        $display("%0t: line_byte expected %h actual %h",
                                 $time, want.ch, line_byte);
                        mismatch_total++;
                    end
                    if (last_of_item !== want.item_end)
                    begin
                        $display("%0t: last_of_item expected %b actual %b",
                                 $time, want.item_end, last_of_item);
                        mismatch_total++;
                    end
                    if (end_of_frame !== want.frame_end)
                    begin
                        $display("%0t: end_of_frame expected %b actual %b",
                                 $time, want.frame_end, end_of_frame);
                        mismatch_total++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("modbus_frame_sender_tb: errors");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] d, input logic lst, input logic chk);
        byte_item_t it;
        it.data = d;
        it.last = lst;
        it.chk = chk;
        pending_bytes.push_back(it);
    endtask

    // Queues random frames totalling n_items bytes. Most frames are short, a
    // few run long. With leave_open the final frame has no closing byte, so a
    // following mode write lands in the middle of a frame.
    task automatic queue_frames(input int n_items, input bit leave_open);
        int left;
        int len;
        logic lst;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                lst = (i == len - 1) && !(leave_open && left == len);
                // Inner bytes carry a random check flag that the framer must ignore.
                queue_byte(8'($urandom_range(255)), lst,
                           lst ? ($urandom_range(2) == 0) : 1'($urandom_range(1)));
            end
            left -= len;
        end
    endtask

    // Lets the queued bytes go through, then waits until every line byte has
    // been seen and the LINE_PAUSE settle time has passed.
    task automatic wait_line_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || line_expect_q.size() != 0);
        repeat (LINE_PAUSE) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        framing_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        mode_now = m;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed RTU frames: single-byte frames at both data extremes, a check
        // flag on an inner byte, and a frame that already carries its CRC.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(FRAMING_BIN);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h03, 1'b0, 1'b0);
        queue_byte(8'hA5, 1'b1, 1'b0);
        queue_byte(8'h11, 1'b0, 1'b0);
        queue_byte(8'h5A, 1'b1, 1'b1);
        wait_line_idle();

        // Directed ASCII frames: single-byte frames at both data extremes, a frame with its own LRC,
        // then a frame left open across a switch to RTU.
        write_mode(FRAMING_HEX);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h9A, 1'b0, 1'b1);
        queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'h3C, 1'b1, 1'b1);
        queue_byte(8'h7E, 1'b0, 1'b0);
        queue_byte(8'h42, 1'b0, 1'b0);
        wait_line_idle();
        // The frame opened in ASCII now closes with an RTU CRC over all its bytes.
        write_mode(FRAMING_BIN);
        queue_byte(8'h81, 1'b1, 1'b0);
        queue_byte(8'hC3, 1'b0, 1'b0);
        queue_byte(8'h6D, 1'b0, 1'b0);
        wait_line_idle();
        // Opened in RTU, so no colon; the ASCII LRC still covers the whole frame.
        write_mode(FRAMING_HEX);
        queue_byte(8'h24, 1'b1, 1'b0);
        wait_line_idle();

        // Random traffic, sender idling lightly and receiver heavily.
        send_idle_pct = 24;
        recv_idle_pct = 59;
        write_mode(FRAMING_BIN);
        queue_frames(60, 1'b1);
        wait_line_idle();

        // Roles swapped; the open frame from above finishes in ASCII.
        send_idle_pct = 59;
        recv_idle_pct = 24;
        write_mode(FRAMING_HEX);
        queue_frames(60, 1'b1);
        wait_line_idle();

        // Full rate both ways, with a full drain in the middle and a mode flip.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'($urandom_range(1)));
        queue_frames(40, 1'b0);
        wait_line_idle();
        queue_frames(20, 1'b1);
        wait_line_idle();
        write_mode(~mode_now);
        queue_frames(30, 1'b0);
        wait_line_idle();

        $display("Run covered %0d frames from %0d RTU and %0d ASCII input bytes,",
                 frames_done, rtu_bytes, ascii_bytes);
        $display("%0d line bytes checked across %0d mode writes.", lines_checked, mode_writes);
        if (mismatch_total == 0)
            $display("modbus_frame_sender_tb: clean");
        else
            $display("modbus_frame_sender_tb: errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_job_builder.sv
hw/rtl/modbus_frame_sender.sv
verif/modbus_frame_sender_tb.sv
